// File: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: src/u8sd_pkg.sv
// Shared types, constants and lead byte classification for the UTF-8 decoder.
package u8sd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned OutDataW = 24;

  localparam logic [LenW-1:0] LenBad = 3'd0;
  localparam logic [LenW-1:0] LenOne = 3'd1;
  localparam logic [LenW-1:0] LenTwo = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;
  localparam logic [LenW-1:0] LenFive = 3'd5;
  localparam logic [LenW-1:0] LenSix = 3'd6;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code_value;
    logic [LenW-1:0]  seq_bytes;
    logic             bad_lead;
  } u8sd_result_t;

  function automatic logic [LenW-1:0] lead_class(input logic [ByteW-1:0] b);
    logic [LenW-1:0] len;
    len = LenBad;
    if (b inside {[8'h00:8'h7F]}) len = LenOne;
    else if (b inside {[8'hC2:8'hDF]}) len = LenTwo;
    else if (b inside {[8'hE0:8'hEF]}) len = LenThree;
    else if (b inside {[8'hF0:8'hF7]}) len = LenFour;
    else if (b inside {[8'hF8:8'hFB]}) len = LenFive;
    else if (b inside {[8'hFC:8'hFD]}) len = LenSix;
    return len;
  endfunction

endpackage

// File: src/u8sd_in_reg.sv
// Input register stage holding one accepted byte.
module u8sd_in_reg
  import u8sd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [ByteW-1:0] s_tdata,
  input  logic             advance,
  output logic             held_valid,
  output logic [ByteW-1:0] held_byte
);

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_byte <= s_tdata;
    end
  end

endmodule

// File: src/u8sd_decode.sv
// Sequence state and per-byte decode logic.
module u8sd_decode
  import u8sd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [ByteW-1:0] in_byte,
  output u8sd_result_t     res
);

  logic [LenW-1:0]  bytes_left, bytes_left_next;
  logic [CodeW-1:0] partial_value, partial_value_next;
  logic [LenW-1:0]  sequence_length, sequence_length_next;
  logic [LenW-1:0]  len;

  assign len = lead_class(in_byte);

  always_comb begin
    bytes_left_next      = bytes_left;
    partial_value_next   = partial_value;
    sequence_length_next = sequence_length;
    res                  = '0;
    if (bytes_left != '0) begin
      partial_value_next = {partial_value[CodeW-7:0], in_byte[5:0]};
      bytes_left_next    = bytes_left - 3'd1;
      if (bytes_left == 3'd1) begin
        sequence_length_next = '0;
        res.valid            = 1'b1;
        res.seq_bytes        = sequence_length;
        res.code_value       = (sequence_length >= LenFive) ? '0 : partial_value_next;
      end
    end else begin
      case (len)
        LenBad: begin
          res.valid     = 1'b1;
          res.seq_bytes = LenOne;
          res.bad_lead  = 1'b1;
        end
        LenOne: begin
          res.valid      = 1'b1;
          res.seq_bytes  = LenOne;
          res.code_value = {{(CodeW-7){1'b0}}, in_byte[6:0]};
        end
        default: begin
          case (len)
            LenTwo:   partial_value_next = {{(CodeW-5){1'b0}}, in_byte[4:0]};
            LenThree: partial_value_next = {{(CodeW-4){1'b0}}, in_byte[3:0]};
            LenFour:  partial_value_next = {{(CodeW-3){1'b0}}, in_byte[2:0]};
            default:  partial_value_next = '0;
          endcase
          sequence_length_next = len;
          bytes_left_next      = len - 3'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left      <= '0;
      partial_value   <= '0;
      sequence_length <= '0;
    end else if (step) begin
      bytes_left      <= bytes_left_next;
      partial_value   <= partial_value_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

// File: src/u8sd_out_reg.sv
// Output register holding one result for the downstream transfer.
module u8sd_out_reg
  import u8sd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  u8sd_result_t        res,
  output logic                out_free,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tuser
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      m_tdata <= {res.seq_bytes, res.code_value};
      m_tuser <= res.bad_lead;
    end
  end

endmodule

// File: src/utf8_stream_decoder.sv
// UTF-8 stream decoder top level.
// Usage:
//   Input channel s_*: one raw UTF-8 byte per transfer in s_tdata.
//   Output channel m_*: one decoded code point per completed sequence.
//   m_tdata carries code_value in [20:0] and seq_bytes in [23:21];
//   m_tuser is set when an invalid lead byte was dropped (value 0, length 1).
//   Bytes of a sequence in progress produce no output transfer.
// Timing:
//   One byte per cycle sustained while m_tready keeps the output register free.
//   The byte that completes a result is held in the input register, then
//   the decode logic loads the output register, which drives m_tvalid.
// Reset:
//   rst clears both pipeline valids and the sequence state; decoding starts
//   fresh with a lead byte.
// Stall:
//   While m_tready is low and a result waits, the pipeline holds; s_tready
//   stays high as long as the input register is empty or can advance.
module utf8_stream_decoder
  import u8sd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] in_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [20:0] code_value, [23:21] seq_bytes
  output logic                m_tuser    // [0] bad_lead
);

  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             out_free;
  logic             step;
  u8sd_result_t     res;

  assign step = held_valid && out_free;

  u8sd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  u8sd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (held_byte),
    .res     (res)
  );

  u8sd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: src/u8sd_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`include "assert_macros.svh"

module u8sd_checker
  import u8sd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata,
  input logic                m_tuser
);

  logic [CodeW-1:0] out_code;
  logic [LenW-1:0]  out_len;

  assign out_code = m_tdata[CodeW-1:0];
  assign out_len  = m_tdata[CodeW +: LenW];

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPLY(a_len_range, clk, rst, m_tvalid, out_len != LenBad && out_len <= LenSix)
  `ASSERT_IMPLY(a_bad_form, clk, rst, m_tvalid && m_tuser, out_code == '0 && out_len == LenOne)
  `ASSERT_IMPLY(a_long_zero, clk, rst, m_tvalid && out_len >= LenFive, out_code == '0 && !m_tuser)
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid)

endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: bench/tb_utf8_stream_decoder.sv
// Self-checking testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8sd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseBytes = 160;

  typedef struct packed {
    logic [CodeW-1:0] code_value;
    logic [LenW-1:0]  seq_bytes;
    logic             bad_lead;
  } code_point_t;

  class code_point_tracker;
    logic [LenW-1:0]  cont_left = '0;
    logic [LenW-1:0]  run_len = '0;
    logic [CodeW-1:0] accum = '0;
    code_point_t      due_points[$];
    int               mismatches = 0;

    function logic [LenW-1:0] lead_length(input logic [ByteW-1:0] b);
      if (!b[7]) return LenOne;
      if (b[7:5] == 3'b110 && b >= 8'hC2) return LenTwo;
      if (b[7:4] == 4'b1110) return LenThree;
      if (b[7:3] == 5'b11110) return LenFour;
      if (b[7:2] == 6'b111110) return LenFive;
      if (b[7:1] == 7'b1111110) return LenSix;
      return LenBad;
    endfunction

    function void decode_byte(input logic [ByteW-1:0] b);
      code_point_t point;
      logic [LenW-1:0] lead_len;
      if (cont_left != '0) begin
        accum = {accum[CodeW-7:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == '0) begin
          point.code_value = (run_len >= LenFive) ? '0 : accum;
          point.seq_bytes = run_len;
          point.bad_lead = 1'b0;
          due_points = {due_points, point};
          run_len = '0;
        end
        return;
      end
      lead_len = lead_length(b);
      case (lead_len)
        LenBad: begin
          point = '{code_value: '0, seq_bytes: LenOne, bad_lead: 1'b1};
          due_points = {due_points, point};
        end
        LenOne: begin
          point = '{code_value: CodeW'(b[6:0]), seq_bytes: LenOne, bad_lead: 1'b0};
          due_points = {due_points, point};
        end
        default: begin
          case (lead_len)
            LenTwo:   accum = CodeW'(b[4:0]);
            LenThree: accum = CodeW'(b[3:0]);
            LenFour:  accum = CodeW'(b[2:0]);
            default:  accum = '0;
          endcase
          run_len = lead_len;
          cont_left = lead_len - 3'd1;
        end
      endcase
    endfunction

    function void check_point(input logic [CodeW-1:0] code_value,
                              input logic [LenW-1:0] seq_bytes, input logic bad_lead);
      code_point_t want;
      if (due_points.size() == 0) begin
        $error("unexpected result: code_value %0h, seq_bytes %0d, bad_lead %0b",
               code_value, seq_bytes, bad_lead);
        mismatches++;
        return;
      end
      want = due_points.pop_front();
      if (code_value !== want.code_value) begin
        $error("code_value: expected %0h, got %0h", want.code_value, code_value);
        mismatches++;
      end
      if (seq_bytes !== want.seq_bytes) begin
        $error("seq_bytes: expected %0d, got %0d", want.seq_bytes, seq_bytes);
        mismatches++;
      end
      if (bad_lead !== want.bad_lead) begin
        $error("bad_lead: expected %0b, got %0b", want.bad_lead, bad_lead);
        mismatches++;
      end
    endfunction

    function int waiting();
      return due_points.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  code_point_tracker tracker;
  int unsigned       src_idle = 0;
  int unsigned       sink_stall = 0;
  logic              hold_off = 1'b0;
  int unsigned       cycle_count = 0;

  logic [ByteW-1:0] directed_bytes [28] = '{
    8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFE, 8'hFF,
    8'hC2, 8'h80,
    8'hDF, 8'h41,
    8'hE0, 8'hBF, 8'hBF,
    8'hF7, 8'hFF, 8'hC0, 8'h3F,
    8'hFB, 8'h80, 8'hBF, 8'h80, 8'hBF,
    8'hFC, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
  };

  utf8_stream_decoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        tracker.check_point(m_tdata[CodeW-1:0], m_tdata[CodeW +: LenW], m_tuser);
      m_tready <= !hold_off && ($urandom_range(99) >= sink_stall);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    tracker.decode_byte(b);
  endtask

  task automatic send_text(input int unsigned target);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    logic [ByteW-1:0] lead;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_byte(ByteW'($urandom_range(255)));
        sent++;
      end else begin
        if (pick < 30) begin
          lead = ByteW'($urandom_range(8'h7F, 8'h00));
          run = 1;
        end else if (pick < 50) begin
          lead = ByteW'($urandom_range(8'hDF, 8'hC2));
          run = 2;
        end else if (pick < 70) begin
          lead = ByteW'($urandom_range(8'hEF, 8'hE0));
          run = 3;
        end else if (pick < 86) begin
          lead = ByteW'($urandom_range(8'hF7, 8'hF0));
          run = 4;
        end else if (pick < 93) begin
          lead = ByteW'($urandom_range(8'hFB, 8'hF8));
          run = 5;
        end else begin
          lead = ByteW'($urandom_range(8'hFD, 8'hFC));
          run = 6;
        end
        if (run > 1 && $urandom_range(99) < 5)
          run = $urandom_range(run - 1, 1);
        send_byte(lead);
        sent++;
        repeat (run - 1) begin
          if ($urandom_range(99) < 92)
            send_byte({2'b10, 6'($urandom_range(63))});
          else
            send_byte(ByteW'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i])
      send_byte(directed_bytes[i]);

    src_idle = 0;
    sink_stall = 0;
    send_text(PhaseBytes);
    src_idle = 75;
    send_text(PhaseBytes);
    src_idle = 0;
    sink_stall = 75;
    send_text(PhaseBytes);
    src_idle = 32;
    sink_stall = 32;
    send_text(PhaseBytes);

    src_idle = 0;
    sink_stall = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_text(PhaseBytes);
      end
    join

    s_tvalid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
